@@ hdl/rotation_matrix_orthonormalize_defines.svh @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_ORTHONORMALIZE_DEFINES_SVH
`define ROTATION_MATRIX_ORTHONORMALIZE_DEFINES_SVH

// Same-cycle implication.
`define RMO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotation_matrix_orthonormalize: same-cycle check failed");

// Next-cycle implication.
`define RMO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotation_matrix_orthonormalize: next-cycle check failed");

`endif

@@ hdl/rmo_pkg.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer package
// Number format, vector and flag types, and the fixed-point rounding helper.
// ---------------------------------------------------------------------------
package rmo_pkg;

    localparam int COMP_W     = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PROD_W     = 2 * COMP_W;
    localparam int SQRT_STEPS = COMP_W;
    localparam int DIV_STEPS  = FRAC_BITS + 1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef comp_t [2:0] vec3_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } flags_t;

    // Divide by 2^FRAC_BITS, rounding to nearest with ties away from zero.
    function automatic comp_t round_shift(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        m = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[PROD_W-1] ? COMP_W'(-m) : COMP_W'(m);
    endfunction

endpackage

@@ hdl/rmo_norm3.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer: vector normalizer
// Sum of squares, pipelined integer square root and pipelined rounding
// division of each component by the length. Side data travels alongside.
// ---------------------------------------------------------------------------
module rmo_norm3 #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rmo_pkg::vec3_t      vec_in,
    input  logic [SIDE_W-1:0]   side_in,
    output rmo_pkg::vec3_t      vec_out,
    output logic                zero,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int MW     = rmo_pkg::COMP_W;
    localparam int SW     = rmo_pkg::PROD_W;
    localparam int SQ     = rmo_pkg::SQRT_STEPS;
    localparam int DV     = rmo_pkg::DIV_STEPS;
    localparam int RW     = MW + 4;
    localparam int NW     = MW + DV;
    localparam int DEN_W  = MW + 1;
    localparam int DREM_W = MW + 2;

    // Front stages
    logic [MW-1:0]     mag1_reg [3];
    logic [2:0]        neg1_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [SW-1:0]     sq2_reg [3];
    logic [MW-1:0]     mag2_reg [3];
    logic [2:0]        neg2_reg;
    logic [SIDE_W-1:0] side2_reg;
    logic [SW-1:0]     sum3_reg;
    logic [MW-1:0]     mag3_reg [3];
    logic [2:0]        neg3_reg;
    logic [SIDE_W-1:0] side3_reg;

    // Square root stages
    logic [SW-1:0]     rad_reg [SQ];
    logic [RW-1:0]     srem_reg [SQ];
    logic [MW-1:0]     root_reg [SQ];
    logic [SW-1:0]     rad_next [SQ];
    logic [RW-1:0]     srem_next [SQ];
    logic [MW-1:0]     root_next [SQ];
    logic [SW-1:0]     rad_src [SQ];
    logic [RW-1:0]     srem_src [SQ];
    logic [MW-1:0]     root_src [SQ];
    logic [MW-1:0]     smag_reg [SQ][3];
    logic [2:0]        sneg_reg [SQ];
    logic              szero_reg [SQ];
    logic [SIDE_W-1:0] sside_reg [SQ];

    // Numerator and denominator stage
    logic [NW-1:0]     num_reg [3];
    logic [DEN_W-1:0]  den_reg;
    logic [2:0]        nneg_reg;
    logic              nzero_reg;
    logic [SIDE_W-1:0] nside_reg;

    // Division stages
    logic [DREM_W-1:0] drem_reg [DV][3];
    logic [DV-1:0]     nlo_reg [DV][3];
    logic [DV-1:0]     quo_reg [DV][3];
    logic [DREM_W-1:0] drem_next [DV][3];
    logic [DV-1:0]     nlo_next [DV][3];
    logic [DV-1:0]     quo_next [DV][3];
    logic [DREM_W-1:0] drem_src [DV][3];
    logic [DV-1:0]     nlo_src [DV][3];
    logic [DV-1:0]     quo_src [DV][3];
    logic [DEN_W-1:0]  dden_reg [DV];
    logic [2:0]        dneg_reg [DV];
    logic              dzero_reg [DV];
    logic [SIDE_W-1:0] dside_reg [DV];

    // Output stage
    rmo_pkg::vec3_t    vec_reg;
    rmo_pkg::vec3_t    vec_next;
    logic              zero_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        logic [RW-1:0] shifted;
        logic [RW-1:0] trial;
        rad_src[0]  = sum3_reg;
        srem_src[0] = '0;
        root_src[0] = '0;
        for (int k = 1; k < SQ; k++)
        begin
            rad_src[k]  = rad_reg[k-1];
            srem_src[k] = srem_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
        for (int k = 0; k < SQ; k++)
        begin
            shifted = {srem_src[k][RW-3:0], rad_src[k][SW-1:SW-2]};
            trial   = {2'b00, root_src[k], 2'b01};
            if (shifted >= trial)
            begin
                srem_next[k] = shifted - trial;
                root_next[k] = {root_src[k][MW-2:0], 1'b1};
            end
            else
            begin
                srem_next[k] = shifted;
                root_next[k] = {root_src[k][MW-2:0], 1'b0};
            end
            rad_next[k] = rad_src[k] << 2;
        end
    end

    always_comb
    begin
        logic [DREM_W-1:0] shifted;
        logic [MW-1:0]     q;
        for (int i = 0; i < 3; i++)
        begin
            drem_src[0][i] = DREM_W'(num_reg[i][NW-1:DV]);
            nlo_src[0][i]  = num_reg[i][DV-1:0];
            quo_src[0][i]  = '0;
        end
        for (int j = 1; j < DV; j++)
        begin
            drem_src[j] = drem_reg[j-1];
            nlo_src[j]  = nlo_reg[j-1];
            quo_src[j]  = quo_reg[j-1];
        end
        for (int j = 0; j < DV; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                shifted = {drem_src[j][i][DREM_W-2:0], nlo_src[j][i][DV-1]};
                if (shifted >= {1'b0, ((j == 0) ? den_reg : dden_reg[(j == 0) ? 0 : j - 1])})
                begin
                    drem_next[j][i] = shifted
                        - {1'b0, ((j == 0) ? den_reg : dden_reg[(j == 0) ? 0 : j - 1])};
                    quo_next[j][i]  = {quo_src[j][i][DV-2:0], 1'b1};
                end
                else
                begin
                    drem_next[j][i] = shifted;
                    quo_next[j][i]  = {quo_src[j][i][DV-2:0], 1'b0};
                end
                nlo_next[j][i] = nlo_src[j][i] << 1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            q = MW'(quo_reg[DV-1][i]);
            vec_next[i] = dneg_reg[DV-1][i] ? -q : q;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= vec_in[i][MW-1] ? MW'(-vec_in[i]) : MW'(vec_in[i]);
                neg1_reg[i] <= vec_in[i][MW-1];
                sq2_reg[i]  <= SW'(mag1_reg[i]) * SW'(mag1_reg[i]);
                num_reg[i]  <= {smag_reg[SQ-1][i], {DV{1'b0}}} + NW'(root_reg[SQ-1]);
            end
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            sum3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            for (int k = 0; k < SQ; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                srem_reg[k] <= srem_next[k];
                root_reg[k] <= root_next[k];
            end
            smag_reg[0]  <= mag3_reg;
            sneg_reg[0]  <= neg3_reg;
            szero_reg[0] <= (sum3_reg == '0);
            for (int k = 1; k < SQ; k++)
            begin
                smag_reg[k]  <= smag_reg[k-1];
                sneg_reg[k]  <= sneg_reg[k-1];
                szero_reg[k] <= szero_reg[k-1];
            end
            den_reg   <= {root_reg[SQ-1], 1'b0};
            nneg_reg  <= sneg_reg[SQ-1];
            nzero_reg <= szero_reg[SQ-1];
            for (int j = 0; j < DV; j++)
            begin
                drem_reg[j] <= drem_next[j];
                nlo_reg[j]  <= nlo_next[j];
                quo_reg[j]  <= quo_next[j];
            end
            dden_reg[0]  <= den_reg;
            dneg_reg[0]  <= nneg_reg;
            dzero_reg[0] <= nzero_reg;
            for (int j = 1; j < DV; j++)
            begin
                dden_reg[j]  <= dden_reg[j-1];
                dneg_reg[j]  <= dneg_reg[j-1];
                dzero_reg[j] <= dzero_reg[j-1];
            end
            vec_reg  <= vec_next;
            zero_reg <= dzero_reg[DV-1];
        end
    end

    // Side data carries the valid bits, so it is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            for (int k = 0; k < SQ; k++)
            begin
                sside_reg[k] <= '0;
            end
            nside_reg <= '0;
            for (int j = 0; j < DV; j++)
            begin
                dside_reg[j] <= '0;
            end
            side_reg <= '0;
        end
        else if (en)
        begin
            side1_reg    <= side_in;
            side2_reg    <= side1_reg;
            side3_reg    <= side2_reg;
            sside_reg[0] <= side3_reg;
            for (int k = 1; k < SQ; k++)
            begin
                sside_reg[k] <= sside_reg[k-1];
            end
            nside_reg    <= sside_reg[SQ-1];
            dside_reg[0] <= nside_reg;
            for (int j = 1; j < DV; j++)
            begin
                dside_reg[j] <= dside_reg[j-1];
            end
            side_reg <= dside_reg[DV-1];
        end
    end

    assign vec_out  = vec_reg;
    assign zero     = zero_reg;
    assign side_out = side_reg;

endmodule

@@ hdl/rmo_ortho.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer: projection removal
// Dot product of the two unit rows and subtraction of the projection of the
// second row onto the first, over six register stages.
// ---------------------------------------------------------------------------
module rmo_ortho (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  rmo_pkg::vec3_t   a_in,
    input  rmo_pkg::vec3_t   b_in,
    input  rmo_pkg::flags_t  flags_in,
    output rmo_pkg::vec3_t   a_out,
    output rmo_pkg::vec3_t   b_out,
    output rmo_pkg::flags_t  flags_out
);

    localparam int SW    = rmo_pkg::PROD_W;
    localparam int DEPTH = 6;

    logic signed [SW-1:0] p1_reg [3];
    logic signed [SW-1:0] dsum2_reg;
    rmo_pkg::comp_t       d3_reg;
    logic signed [SW-1:0] e4_reg [3];
    rmo_pkg::vec3_t       r5_reg;
    rmo_pkg::vec3_t       b6_reg;
    rmo_pkg::vec3_t       a_pipe_reg [DEPTH];
    rmo_pkg::vec3_t       b_pipe_reg [DEPTH-1];
    rmo_pkg::flags_t      flags_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= $signed(a_in[i]) * $signed(b_in[i]);
                e4_reg[i] <= $signed(d3_reg) * $signed(a_pipe_reg[2][i]);
                r5_reg[i] <= rmo_pkg::round_shift(e4_reg[i]);
                b6_reg[i] <= b_pipe_reg[4][i] - r5_reg[i];
            end
            dsum2_reg <= p1_reg[0] + p1_reg[1] + p1_reg[2];
            d3_reg    <= rmo_pkg::round_shift(dsum2_reg);
            a_pipe_reg[0] <= a_in;
            b_pipe_reg[0] <= b_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                a_pipe_reg[k] <= a_pipe_reg[k-1];
            end
            for (int k = 1; k < DEPTH - 1; k++)
            begin
                b_pipe_reg[k] <= b_pipe_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                flags_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            flags_reg[0] <= flags_in;
            for (int k = 1; k < DEPTH; k++)
            begin
                flags_reg[k] <= flags_reg[k-1];
            end
        end
    end

    assign a_out     = a_pipe_reg[DEPTH-1];
    assign b_out     = b6_reg;
    assign flags_out = flags_reg[DEPTH-1];

endmodule

@@ hdl/rmo_cross.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer: cross product and output register
// Third row from the two cleaned rows; the last stage holds the result and
// clears it when any row had zero length.
// ---------------------------------------------------------------------------
module rmo_cross (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  rmo_pkg::vec3_t   a_in,
    input  rmo_pkg::vec3_t   b_in,
    input  rmo_pkg::flags_t  flags_in,
    output rmo_pkg::vec3_t   a_out,
    output rmo_pkg::vec3_t   b_out,
    output rmo_pkg::vec3_t   c_out,
    output logic             degenerate,
    output logic             valid
);

    localparam int SW = rmo_pkg::PROD_W;

    logic signed [SW-1:0] pp1_reg [3];
    logic signed [SW-1:0] pn1_reg [3];
    logic signed [SW-1:0] diff2_reg [3];
    rmo_pkg::vec3_t       a1_reg, a2_reg, a3_reg;
    rmo_pkg::vec3_t       b1_reg, b2_reg, b3_reg;
    rmo_pkg::vec3_t       c3_reg;
    rmo_pkg::flags_t      flags1_reg, flags2_reg;
    logic                 bad3_reg;
    logic                 valid3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp1_reg[i]   <= $signed(a_in[(i+1)%3]) * $signed(b_in[(i+2)%3]);
                pn1_reg[i]   <= $signed(a_in[(i+2)%3]) * $signed(b_in[(i+1)%3]);
                diff2_reg[i] <= pp1_reg[i] - pn1_reg[i];
                c3_reg[i]    <= flags2_reg.bad ? '0 : rmo_pkg::round_shift(diff2_reg[i]);
            end
            a1_reg   <= a_in;
            b1_reg   <= b_in;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            a3_reg   <= flags2_reg.bad ? '0 : a2_reg;
            b3_reg   <= flags2_reg.bad ? '0 : b2_reg;
            bad3_reg <= flags2_reg.bad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags1_reg <= '0;
            flags2_reg <= '0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            flags1_reg <= flags_in;
            flags2_reg <= flags1_reg;
            valid3_reg <= flags2_reg.valid;
        end
    end

    assign a_out      = a3_reg;
    assign b_out      = b3_reg;
    assign c_out      = c3_reg;
    assign degenerate = bad3_reg;
    assign valid      = valid3_reg;

endmodule

@@ hdl/rotation_matrix_orthonormalize.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer
// Gram-Schmidt cleanup of a rotation matrix in signed Q3.28 fixed point.
// ---------------------------------------------------------------------------
// The input channel carries the first two rows of a matrix; a transfer takes
// place when in_valid and in_ready are both high. The output channel carries
// the two cleaned rows, their cross product and a degenerate flag, which is
// set (with all nine components zero) when a row has zero length.
// From input transfer to out_valid the matrix passes two normalizers of
// 66 stages each (3 for the sum of squares, 32 square root steps, one
// numerator stage, 29 divide steps, one sign stage), 6 for the projection
// and 3 for the cross product and output register. A new matrix is taken in
// every cycle while the output is not stalled; the one-bit-per-stage root and
// quotient pipelines set the depth, not the rate.
// All stages advance together. When a result sits in the output register and
// out_ready is low, the whole pipeline holds and in_ready drops; nothing is
// lost or repeated. Reset clears every valid bit, so the block comes up empty.
// ---------------------------------------------------------------------------
module rotation_matrix_orthonormalize (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] row_a_x,
    input  logic [31:0] row_a_y,
    input  logic [31:0] row_a_z,
    input  logic [31:0] row_b_x,
    input  logic [31:0] row_b_y,
    input  logic [31:0] row_b_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_a_x,
    output logic [31:0] out_a_y,
    output logic [31:0] out_a_z,
    output logic [31:0] out_b_x,
    output logic [31:0] out_b_y,
    output logic [31:0] out_b_z,
    output logic [31:0] out_c_x,
    output logic [31:0] out_c_y,
    output logic [31:0] out_c_z,
    output logic        degenerate
);

    localparam int SIDE2_W = $bits(rmo_pkg::flags_t) + $bits(rmo_pkg::vec3_t);

    logic                 en;
    rmo_pkg::vec3_t       a_in, b_in;
    rmo_pkg::vec3_t       a_n, b_n;
    logic                 zero_a, zero_b;
    logic                 valid_a, valid_b;
    rmo_pkg::flags_t      flags1;
    rmo_pkg::vec3_t       a_o, b_o;
    rmo_pkg::flags_t      flags_o;
    rmo_pkg::vec3_t       b_n2;
    logic                 zero_b2;
    logic [SIDE2_W-1:0]   side2_out;
    rmo_pkg::flags_t      flags2;
    rmo_pkg::flags_t      flags3;
    rmo_pkg::vec3_t       a3;
    rmo_pkg::vec3_t       oa, ob, oc;
    logic                 out_valid_w;

    assign en       = !out_valid_w || out_ready;
    assign in_ready = en;

    assign a_in = {row_a_z, row_a_y, row_a_x};
    assign b_in = {row_b_z, row_b_y, row_b_x};

    rmo_norm3 #(.SIDE_W(1)) u_norm_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec_in   (a_in),
        .side_in  (in_valid),
        .vec_out  (a_n),
        .zero     (zero_a),
        .side_out (valid_a)
    );

    rmo_norm3 #(.SIDE_W(1)) u_norm_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec_in   (b_in),
        .side_in  (in_valid),
        .vec_out  (b_n),
        .zero     (zero_b),
        .side_out (valid_b)
    );

    assign flags1 = '{valid: valid_a && valid_b, bad: zero_a || zero_b};

    rmo_ortho u_ortho (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .a_in      (a_n),
        .b_in      (b_n),
        .flags_in  (flags1),
        .a_out     (a_o),
        .b_out     (b_o),
        .flags_out (flags_o)
    );

    // The second normalizer carries the unit first row and the flags along.
    rmo_norm3 #(.SIDE_W(SIDE2_W)) u_norm_b2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec_in   (b_o),
        .side_in  ({flags_o, a_o}),
        .vec_out  (b_n2),
        .zero     (zero_b2),
        .side_out (side2_out)
    );

    assign {flags2, a3} = side2_out;
    assign flags3 = '{valid: flags2.valid, bad: flags2.bad || zero_b2};

    rmo_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .a_in       (a3),
        .b_in       (b_n2),
        .flags_in   (flags3),
        .a_out      (oa),
        .b_out      (ob),
        .c_out      (oc),
        .degenerate (degenerate),
        .valid      (out_valid_w)
    );

    assign out_valid = out_valid_w;
    assign out_a_x   = oa[0];
    assign out_a_y   = oa[1];
    assign out_a_z   = oa[2];
    assign out_b_x   = ob[0];
    assign out_b_y   = ob[1];
    assign out_b_z   = ob[2];
    assign out_c_x   = oc[0];
    assign out_c_y   = oc[1];
    assign out_c_z   = oc[2];

endmodule

@@ hdl/rmo_checker.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer: port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`include "rotation_matrix_orthonormalize_defines.svh"

module rmo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_a_x,
    input logic [31:0] out_b_y,
    input logic [31:0] out_c_z,
    input logic        degenerate
);

    // A held result keeps its payload.
    `RMO_ASSERT_NEXT(hold_result, out_valid && !out_ready,
        out_valid && $stable(out_a_x) && $stable(out_c_z) && $stable(degenerate))

    // The pipeline advances exactly when the output register can move.
    `RMO_ASSERT_NOW(ready_follows_output, 1'b1, in_ready == (!out_valid || out_ready))

    // A degenerate result carries zero components.
    `RMO_ASSERT_NOW(degenerate_zero, out_valid && degenerate,
        out_a_x == 32'd0 && out_b_y == 32'd0 && out_c_z == 32'd0)

endmodule

bind rotation_matrix_orthonormalize rmo_checker u_rmo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_a_x    (out_a_x),
    .out_b_y    (out_b_y),
    .out_c_z    (out_c_z),
    .degenerate (degenerate)
);

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// Rotation matrix orthonormalizer testbench
// Streams pairs of matrix rows through the block and checks every cleaned
// matrix and its degenerate flag against a fixed-point predictor, with
// random gaps on the input side and random stalls on the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef logic [31:0] word_t;

    typedef struct {
        word_t comp[9];
        logic  degen;
    } cleaned_matrix_t;

    localparam int ONE_Q = 1 << rmo_pkg::FRAC_BITS;

    class matrix_scoreboard;
        cleaned_matrix_t expected_q[$];
        int errors;
        int checked;
        int degen_seen;
        string comp_names[9] = '{"out_a_x", "out_a_y", "out_a_z", "out_b_x", "out_b_y",
                                 "out_b_z", "out_c_x", "out_c_y", "out_c_z"};

        function new();
            errors = 0;
            checked = 0;
            degen_seen = 0;
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function automatic longint unsigned magnitude(longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function automatic longint round_frac(longint v);
            longint unsigned m;
            m = (magnitude(v) + (longint'(1) << (rmo_pkg::FRAC_BITS - 1)))
                >> rmo_pkg::FRAC_BITS;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned s);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (s >= res + bitv)
                begin
                    s -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // Scales a vector to unit length; returns 0 when it has zero length.
        function automatic bit to_unit(inout longint v[3]);
            longint unsigned s;
            longint unsigned r;
            longint unsigned n;
            longint unsigned q;
            s = 0;
            for (int i = 0; i < 3; i++)
                s += magnitude(v[i]) * magnitude(v[i]);
            if (s == 0)
                return 0;
            r = int_sqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                n = magnitude(v[i]) << rmo_pkg::FRAC_BITS;
                q = (2 * n + r) / (2 * r);
                v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function automatic word_t clamp32(longint v);
            if (v > 64'sh7FFF_FFFF)
                v = 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000)
                v = -64'sh8000_0000;
            return v[31:0];
        endfunction

        function automatic cleaned_matrix_t orthonormalize(word_t rows[6]);
            cleaned_matrix_t res;
            longint a[3];
            longint b[3];
            longint c[3];
            longint d;
            bit ok;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = longint'(signed'(rows[i]));
                b[i] = longint'(signed'(rows[3 + i]));
            end
            ok = to_unit(a);
            ok = to_unit(b) && ok;
            if (ok)
            begin
                d = round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
                for (int i = 0; i < 3; i++)
                    b[i] -= round_frac(d * a[i]);
                ok = to_unit(b);
            end
            if (!ok)
            begin
                foreach (res.comp[i])
                    res.comp[i] = '0;
                res.degen = 1'b1;
                return res;
            end
            c[0] = round_frac(a[1] * b[2] - a[2] * b[1]);
            c[1] = round_frac(a[2] * b[0] - a[0] * b[2]);
            c[2] = round_frac(a[0] * b[1] - a[1] * b[0]);
            for (int i = 0; i < 3; i++)
            begin
                res.comp[i] = clamp32(a[i]);
                res.comp[3 + i] = clamp32(b[i]);
                res.comp[6 + i] = clamp32(c[i]);
            end
            res.degen = 1'b0;
            return res;
        endfunction

        function void note_rows(word_t rows[6]);
            expected_q.push_back(orthonormalize(rows));
        endfunction

        task check_matrix(cleaned_matrix_t got);
            cleaned_matrix_t want;
            if (expected_q.size() == 0)
            begin
                report("result transfer with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.degen)
                degen_seen++;
            foreach (got.comp[i])
                if (got.comp[i] !== want.comp[i])
                    report($sformatf("%s got %h expected %h", comp_names[i],
                                     got.comp[i], want.comp[i]));
            if (got.degen !== want.degen)
                report($sformatf("degenerate got %b expected %b", got.degen, want.degen));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    word_t row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z;
    logic out_valid;
    logic out_ready;
    word_t out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z;
    word_t out_c_x, out_c_y, out_c_z;
    logic degenerate;

    matrix_scoreboard sb;
    int sent;

    rotation_matrix_orthonormalize dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .row_a_x    (row_a_x),
        .row_a_y    (row_a_y),
        .row_a_z    (row_a_z),
        .row_b_x    (row_b_x),
        .row_b_y    (row_b_y),
        .row_b_z    (row_b_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_a_x    (out_a_x),
        .out_a_y    (out_a_y),
        .out_a_z    (out_a_z),
        .out_b_x    (out_b_x),
        .out_b_y    (out_b_y),
        .out_b_z    (out_b_z),
        .out_c_x    (out_c_x),
        .out_c_y    (out_c_y),
        .out_c_z    (out_c_z),
        .degenerate (degenerate)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Both transfers are observed at the rising edge.
    always @(posedge clk)
    begin
        cleaned_matrix_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_rows('{row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z});
            if (out_valid && out_ready)
            begin
                got.comp = '{out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
                             out_c_x, out_c_y, out_c_z};
                got.degen = degenerate;
                sb.check_matrix(got);
            end
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The receiver alternates between random stalls and runs of steady readiness.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 9) < 3)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge clk);
            end
            else
            begin
                hold = gap_length();
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task send_rows(word_t rows[6]);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {row_a_x, row_a_y, row_a_z} <= {rows[0], rows[1], rows[2]};
        {row_b_x, row_b_y, row_b_z} <= {rows[3], rows[4], rows[5]};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic word_t rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return word_t'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
            2: return word_t'($urandom_range(0, 64) - 32);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return word_t'(0);
            default: return word_t'($urandom_range(0, 2 * ONE_Q / 16) - ONE_Q / 16);
        endcase
    endfunction

    task random_item();
        word_t r[6];
        int kind;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 50)
        begin
            // Nearly orthonormal rows with a little drift.
            r = '{word_t'(ONE_Q), 0, 0, 0, word_t'(ONE_Q), 0};
            if ($urandom_range(0, 1))
                r = '{0, 0, word_t'(-ONE_Q), word_t'(ONE_Q), 0, 0};
            foreach (r[i])
                r[i] = r[i] + word_t'($urandom_range(0, 1 << 22) - (1 << 21));
        end
        else if (kind < 85)
        begin
            foreach (r[i])
                r[i] = rand_comp();
        end
        else if (kind < 95)
        begin
            // Second row a multiple of the first: parallel rows.
            k = $urandom_range(0, 6) - 3;
            for (int i = 0; i < 3; i++)
            begin
                r[i] = word_t'($urandom_range(0, 1 << 20) - (1 << 19));
                r[3 + i] = r[i] * k;
            end
        end
        else
        begin
            foreach (r[i])
                r[i] = rand_comp();
            for (int i = 0; i < 3; i++)
                r[($urandom_range(0, 1) * 3) + i] = '0;
        end
        send_rows(r);
    endtask

    initial
    begin
        word_t dir[$][6];
        sb = new();
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {row_a_x, row_a_y, row_a_z, row_b_x, row_b_y, row_b_z} = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        dir.push_back('{0, 0, 0, 0, 0, 0});
        dir.push_back('{0, 0, 0, word_t'(ONE_Q), 0, 0});
        dir.push_back('{word_t'(ONE_Q), 0, 0, 0, 0, 0});
        dir.push_back('{word_t'(ONE_Q), 0, 0, 0, word_t'(ONE_Q), 0});
        dir.push_back('{0, word_t'(ONE_Q), 0, 0, 0, word_t'(ONE_Q)});
        dir.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        dir.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
        dir.push_back('{32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0});
        dir.push_back('{32'h1234_5678, 32'h0ABC_DEF0, 32'hF000_0001,
                        32'h1234_5678, 32'h0ABC_DEF0, 32'hF000_0001});
        dir.push_back('{32'h1234_5678, 32'h0ABC_DEF0, 32'hF000_0001,
                        32'hEDCB_A988, 32'hF543_2110, 32'h0FFF_FFFF});
        dir.push_back('{1, 0, 0, 2, 0, 0});
        dir.push_back('{1, 1, 1, 32'hFFFF_FFFF, 1, 0});
        dir.push_back('{0, 0, 1, 0, 1, 0});
        dir.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE});
        dir.push_back('{32'h1000_0100, 32'h0000_3000, 32'hFFF0_0000,
                        32'h0001_0000, 32'h0FFF_F000, 32'h0020_0000});
        dir.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000});
        dir.push_back('{32'h0B50_4F33, 32'h0B50_4F33, 0, 32'hF4AF_B0CD, 32'h0B50_4F33, 0});
        foreach (dir[i])
            send_rows(dir[i]);

        // Let the pipeline empty completely before the random stream.
        drain();

        repeat (1080)
            random_item();
        drain();
        repeat (200) @(posedge clk);

        $display("Sent %0d matrices, checked %0d cleaned results (%0d degenerate).",
                 sent, sb.checked, sb.degen_seen);
        $display("Stimulus mixed near-rotations, full-range words, parallel and zero rows.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Run timed out with %0d results outstanding.", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
